FILE: hdl/conv_encoder_with_poison_defines.svh
// Assertion macros shared by the convolutional encoder RTL.
`ifndef CONV_ENCODER_WITH_POISON_DEFINES_SVH
`define CONV_ENCODER_WITH_POISON_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CENC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CENC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cenc_pkg.sv
// Types and constants for the convolutional encoder.
`timescale 1ns / 1ps

package cenc_pkg;

    // Field widths fixed by the interface
    localparam int GEN_W     = 9;
    localparam int CLEN_W    = 4;
    localparam int NOUT_W    = 3;
    localparam int SYM_W     = 2;
    localparam int NUM_SYM   = 4;
    localparam int MAX_N     = 4;
    localparam int CFG_IDX_W = 3;

    // Request kinds carried in s_tuser
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // Input symbol codes
    localparam logic [SYM_W-1:0] IN_FALSE   = 2'd0;
    localparam logic [SYM_W-1:0] IN_TRUE    = 2'd1;
    localparam logic [SYM_W-1:0] IN_ERASURE = 2'd2;
    localparam logic [SYM_W-1:0] IN_INVALID = 2'd3;

    // Coded symbol codes
    localparam logic [SYM_W-1:0] SYM_FALSE  = 2'd0;
    localparam logic [SYM_W-1:0] SYM_POISON = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONSTRAINT_LEN = 3'd0,
        CFG_NUM_OUTPUTS    = 3'd1,
        CFG_GEN_0          = 3'd2,
        CFG_GEN_1          = 3'd3,
        CFG_GEN_2          = 3'd4,
        CFG_GEN_3          = 3'd5
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [CLEN_W-1:0] RST_CONSTRAINT_LEN = 4'd7;
    localparam logic [NOUT_W-1:0] RST_NUM_OUTPUTS    = 3'd2;
    localparam logic [GEN_W-1:0]  RST_GEN_0          = 9'd121;
    localparam logic [GEN_W-1:0]  RST_GEN_1          = 9'd91;
    localparam logic [GEN_W-1:0]  RST_GEN_2          = 9'd0;
    localparam logic [GEN_W-1:0]  RST_GEN_3          = 9'd0;

endpackage

FILE: hdl/conv_encoder_with_poison.sv
// Feedforward convolutional encoder with unknown-value (poison) tracking.
`timescale 1ns / 1ps

// Convolutional encoder, constraint length 2..MAX_K, up to four coded symbols per
// group. Each input beat carries one symbol (false, true, erasure, invalid) or a
// flush request. Erasure and invalid enter the shift register as 0 and mark the
// position unknown; a coded symbol whose generator taps an unknown position comes
// out as poison. An encode beat yields one group, with tlast set. A flush beat yields
// K-1 groups, one per cycle while m_tready holds, only the last with tlast; the input
// stays stalled until the last one has been loaded. Throughput is one group per cycle
// while m_tready holds, set by the single output register. The user must write the
// configuration through cfg_wr_en/cfg_addr/cfg_wdata only while idle (not enforced).
module conv_encoder_with_poison #(
    parameter int MAX_K = 9
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [cenc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [cenc_pkg::GEN_W-1:0]      cfg_wdata,

    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [1:0] in_symbol, [7:2] zero
    input  logic                            s_tuser,   // [0] req_type

    // coded groups
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [1:0] out_sym_0 .. [7:6] out_sym_3
    output logic                            m_tlast    // group_last
);

    `include "conv_encoder_with_poison_defines.svh"

    localparam int KW  = $clog2(MAX_K + 1);   // holds K
    localparam int KIW = $clog2(MAX_K);       // indexes the K-bit register
    localparam int SW  = MAX_K - 1;           // state width

    // configuration registers
    logic [cenc_pkg::CLEN_W-1:0] clen_reg;
    logic [cenc_pkg::NOUT_W-1:0] nout_reg;
    logic [cenc_pkg::GEN_W-1:0]  gen_reg [cenc_pkg::NUM_SYM];

    // encoder state
    logic [SW-1:0]  trellis_reg, trellis_next;
    logic [SW-1:0]  unk_reg, unk_next;
    logic [KIW-1:0] flush_cnt_reg, flush_cnt_next;

    // output register
    logic                                 m_valid_reg, m_valid_next;
    logic [cenc_pkg::SYM_W-1:0]           sym_reg [cenc_pkg::NUM_SYM];
    logic [cenc_pkg::SYM_W-1:0]           sym_next [cenc_pkg::NUM_SYM];
    logic                                 last_reg, last_next;

    logic           out_free;
    logic           load_in;
    logic           load_flush;
    logic           load_grp;
    logic           new_bit;
    logic           new_unk;
    logic [KW-1:0]  eff_k;
    logic [KIW-1:0] km1;
    logic [cenc_pkg::NOUT_W-1:0] eff_n;
    logic [SW-1:0]  smask;
    logic [MAX_K-1:0] reg_vec;
    logic [MAX_K-1:0] regu_vec;
    logic [MAX_K-1:0] tap;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clen_reg   <= cenc_pkg::RST_CONSTRAINT_LEN;
            nout_reg   <= cenc_pkg::RST_NUM_OUTPUTS;
            gen_reg[0] <= cenc_pkg::RST_GEN_0;
            gen_reg[1] <= cenc_pkg::RST_GEN_1;
            gen_reg[2] <= cenc_pkg::RST_GEN_2;
            gen_reg[3] <= cenc_pkg::RST_GEN_3;
        end else if (cfg_wr_en) begin
            case (cenc_pkg::cfg_idx_t'(cfg_addr))
                cenc_pkg::CFG_CONSTRAINT_LEN: clen_reg   <= cfg_wdata[cenc_pkg::CLEN_W-1:0];
                cenc_pkg::CFG_NUM_OUTPUTS:    nout_reg   <= cfg_wdata[cenc_pkg::NOUT_W-1:0];
                cenc_pkg::CFG_GEN_0:          gen_reg[0] <= cfg_wdata;
                cenc_pkg::CFG_GEN_1:          gen_reg[1] <= cfg_wdata;
                cenc_pkg::CFG_GEN_2:          gen_reg[2] <= cfg_wdata;
                cenc_pkg::CFG_GEN_3:          gen_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp K and n to their legal ranges
    always_comb begin
        if (int'(clen_reg) < 2) begin
            eff_k = KW'(2);
        end else if (int'(clen_reg) > MAX_K) begin
            eff_k = KW'(MAX_K);
        end else begin
            eff_k = KW'(clen_reg);
        end
        km1 = KIW'(eff_k - KW'(1));

        if (nout_reg == '0) begin
            eff_n = cenc_pkg::NOUT_W'(1);
        end else if (int'(nout_reg) > cenc_pkg::MAX_N) begin
            eff_n = cenc_pkg::NOUT_W'(cenc_pkg::MAX_N);
        end else begin
            eff_n = nout_reg;
        end
    end

    // handshake
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (flush_cnt_reg == '0) && out_free;
    assign load_in    = s_tvalid && s_tready;
    assign load_flush = (flush_cnt_reg != '0) && out_free;
    assign load_grp   = load_in || load_flush;

    // select the bit entering the register and the group's last flag
    always_comb begin
        new_bit        = 1'b0;
        new_unk        = 1'b0;
        last_next      = last_reg;
        flush_cnt_next = flush_cnt_reg;
        if (load_in && s_tuser == cenc_pkg::REQ_ENCODE) begin
            // erasure and invalid both have the upper code bit set
            new_unk   = s_tdata[1];
            new_bit   = !s_tdata[1] && s_tdata[0];
            last_next = 1'b1;
        end else if (load_in) begin
            last_next      = (km1 == KIW'(1));
            flush_cnt_next = KIW'(km1 - KIW'(1));
        end else if (load_flush) begin
            last_next      = (flush_cnt_reg == KIW'(1));
            flush_cnt_next = KIW'(flush_cnt_reg - KIW'(1));
        end
    end

    // build the K-bit register and its unknown mask, then the next state
    always_comb begin
        for (int i = 0; i < SW; i++) begin
            smask[i] = (i < int'(km1));
        end
        for (int i = 0; i < MAX_K; i++) begin
            if (i == int'(km1)) begin
                reg_vec[i]  = new_bit;
                regu_vec[i] = new_unk;
            end else if (i < int'(km1)) begin
                reg_vec[i]  = trellis_reg[i];
                regu_vec[i] = unk_reg[i];
            end else begin
                reg_vec[i]  = 1'b0;
                regu_vec[i] = 1'b0;
            end
        end
        for (int i = 0; i < SW; i++) begin
            trellis_next[i] = reg_vec[i+1] & smask[i];
            unk_next[i]     = regu_vec[i+1] & smask[i];
        end
    end

    // coded symbols: false beyond n, poison on any unknown tap, else parity of the taps
    always_comb begin
        tap = '0;
        for (int j = 0; j < cenc_pkg::NUM_SYM; j++) begin
            tap = MAX_K'(gen_reg[j]);
            if (j >= int'(eff_n)) begin
                sym_next[j] = cenc_pkg::SYM_FALSE;
            end else if (|(tap & regu_vec)) begin
                sym_next[j] = cenc_pkg::SYM_POISON;
            end else begin
                sym_next[j] = {1'b0, ^(tap & reg_vec)};
            end
        end
    end

    always_comb begin
        if (load_grp) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trellis_reg   <= '0;
            unk_reg       <= '0;
            flush_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            flush_cnt_reg <= flush_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (load_grp) begin
                trellis_reg <= trellis_next;
                unk_reg     <= unk_next;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load_grp) begin
            for (int j = 0; j < cenc_pkg::NUM_SYM; j++) begin
                sym_reg[j] <= sym_next[j];
            end
            last_reg <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {sym_reg[3], sym_reg[2], sym_reg[1], sym_reg[0]};
    assign m_tlast  = last_reg;

    // checks
    `CENC_ASSERT_NXT(a_encode_one_group, aclk, aresetn,
        load_in && s_tuser == cenc_pkg::REQ_ENCODE, m_valid_reg && last_reg,
        "encode beat did not produce a last group")
    `CENC_ASSERT_IMP(a_no_last_mid_flush, aclk, aresetn,
        m_valid_reg && flush_cnt_reg != '0, !last_reg,
        "last flag set while flush groups remain")
    `CENC_ASSERT_NXT(a_flush_ends_last, aclk, aresetn,
        load_flush && flush_cnt_reg == KIW'(1), m_valid_reg && last_reg,
        "final flush group not flagged last")

endmodule
